// ===== hw/rtl/nearest_neighbor_scaler_addr_assert.svh =====
// Assertion macros for the nearest-neighbor scaler address generator.
// Used by the port checker; needs clock and reset in scope.
`ifndef NEAREST_NEIGHBOR_SCALER_ADDR_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALER_ADDR_ASSERT_SVH

// Check a property outside reset.
`define NNSA_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every edge, reset included.
`define NNSA_CHECK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/nnsa_pkg.sv =====
// Shared types and constants of the nearest-neighbor scaler address generator.
// No dependencies; imported by every module of the block.
package nnsa_pkg;

   localparam int ADDR_W     = 24;
   localparam int DIM_W      = 13;
   localparam int CNT_W      = 12;
   localparam int MAX_DIM    = 4096;
   localparam int QUO_W      = 24;
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 2 * ADDR_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_BASE,
      REG_SRC_PITCH,
      REG_SRC_WIDTH,
      REG_SRC_HEIGHT,
      REG_DST_BASE,
      REG_DST_PITCH,
      REG_DST_WIDTH,
      REG_DST_HEIGHT
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_X,
      ST_DIV_X,
      ST_DIV_Y,
      ST_OFFSET,
      ST_SUM
   } state_type;

   typedef struct packed {
      logic emit;
      logic clear;
      logic div_start;
      logic div_sel_y;
      logic cap_x;
      logic cap_y;
      logic calc_off;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic dims_empty;
      logic pix_last;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

endpackage

// ===== hw/rtl/nnsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the scale indexes.
// Depends on nnsa_pkg.
module nnsa_div
   import nnsa_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nnsa_pkg::QUO_W-1:0] dividend,
   input  logic [nnsa_pkg::DIM_W-1:0] divisor,
   output logic                       done,
   output logic [nnsa_pkg::QUO_W-1:0] quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [DIM_W-1:0]     div_ff, div_in;
   logic [DIM_W-1:0]     rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[DIM_W-2:0], quo_ff[QUO_W-1]};
      ge      = (rem_sh >= div_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], ge};
         rem_in = ge ? (rem_sh - div_ff) : rem_sh;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = (div_ff == '0) ? '0 : quo_ff;

endmodule

// ===== hw/rtl/nnsa_dp.sv =====
// Datapath: registers, pixel counters, products, divider and output register.
// Depends on nnsa_pkg and nnsa_div.
module nnsa_dp
   import nnsa_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  nnsa_pkg::cmd_type               cmd,
   output nnsa_pkg::status_type            status,
   input  logic                            csr_wen,
   input  logic [nnsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_restart,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nnsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam int PROD_W = CNT_W + DIM_W;
   localparam int SPROD_W = QUO_W + DIM_W;

   logic [ADDR_W-1:0] src_base_ff, dst_base_ff;
   logic [DIM_W-1:0]  src_pitch_ff, src_width_ff, src_height_ff;
   logic [DIM_W-1:0]  dst_pitch_ff, dst_width_ff, dst_height_ff;

   logic [CNT_W-1:0]  col_ff, row_ff, cur_col_ff, cur_row_ff;
   logic              last_ff;
   logic [QUO_W-1:0]  sx_ff, sy_ff;
   logic [ADDR_W-1:0] src_off_ff, dst_off_ff;
   logic              out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic              out_last_ff;

   logic [DIM_W-1:0]  sw_c, sh_c, dw_c, dh_c;
   logic [CNT_W-1:0]  pix_col, pix_row;
   logic              row_end, pix_last;
   logic [PROD_W-1:0] prod_x, prod_y, prod_d;
   logic [SPROD_W-1:0] prod_s;
   logic [QUO_W-1:0]  div_dividend, div_quotient;
   logic [DIM_W-1:0]  div_divisor;
   logic              div_done;
   logic [ADDR_W-1:0] src_sum, dst_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_base_ff   <= '0;
         src_pitch_ff  <= DIM_W'(1);
         src_width_ff  <= '0;
         src_height_ff <= '0;
         dst_base_ff   <= '0;
         dst_pitch_ff  <= DIM_W'(1);
         dst_width_ff  <= '0;
         dst_height_ff <= '0;
      end else if (csr_wen) begin
         case (csr_reg_type'(csr_index))
            REG_SRC_BASE:   src_base_ff   <= csr_wdata[ADDR_W-1:0];
            REG_SRC_PITCH:  src_pitch_ff  <= csr_wdata[DIM_W-1:0];
            REG_SRC_WIDTH:  src_width_ff  <= csr_wdata[DIM_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_wdata[DIM_W-1:0];
            REG_DST_BASE:   dst_base_ff   <= csr_wdata[ADDR_W-1:0];
            REG_DST_PITCH:  dst_pitch_ff  <= csr_wdata[DIM_W-1:0];
            REG_DST_WIDTH:  dst_width_ff  <= csr_wdata[DIM_W-1:0];
            REG_DST_HEIGHT: dst_height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sw_c     = clamp_dim(src_width_ff);
      sh_c     = clamp_dim(src_height_ff);
      dw_c     = clamp_dim(dst_width_ff);
      dh_c     = clamp_dim(dst_height_ff);
      pix_col  = req_restart ? '0 : col_ff;
      pix_row  = req_restart ? '0 : row_ff;
      row_end  = ((DIM_W'(pix_col) + DIM_W'(1)) >= dw_c);
      pix_last = row_end && ((DIM_W'(pix_row) + DIM_W'(1)) >= dh_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.clear) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.emit) begin
         if (pix_last) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (row_end) begin
            col_ff <= '0;
            row_ff <= pix_row + CNT_W'(1);
         end else begin
            col_ff <= pix_col + CNT_W'(1);
            row_ff <= pix_row;
         end
      end
   end

   always_comb begin
      prod_x       = PROD_W'(cur_col_ff) * PROD_W'(sw_c);
      prod_y       = PROD_W'(cur_row_ff) * PROD_W'(sh_c);
      prod_d       = PROD_W'(cur_row_ff) * PROD_W'(dst_pitch_ff);
      prod_s       = SPROD_W'(sy_ff) * SPROD_W'(src_pitch_ff);
      div_dividend = cmd.div_sel_y ? prod_y[QUO_W-1:0] : prod_x[QUO_W-1:0];
      div_divisor  = cmd.div_sel_y ? dh_c : dw_c;
      src_sum      = src_base_ff + src_off_ff + sx_ff[ADDR_W-1:0];
      dst_sum      = dst_base_ff + dst_off_ff + ADDR_W'(cur_col_ff);
   end

   nnsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         cur_col_ff <= pix_col;
         cur_row_ff <= pix_row;
         last_ff    <= pix_last;
      end
      if (cmd.cap_x) begin
         sx_ff <= div_quotient;
      end
      if (cmd.cap_y) begin
         sy_ff <= div_quotient;
      end
      if (cmd.calc_off) begin
         src_off_ff <= prod_s[ADDR_W-1:0];
         dst_off_ff <= prod_d[ADDR_W-1:0];
      end
      if (cmd.load_out) begin
         out_data_ff <= {dst_sum, src_sum};
         out_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign status.dims_empty = (dst_width_ff == '0) || (dst_height_ff == '0);
   assign status.pix_last   = pix_last;
   assign status.div_done   = div_done;
   assign status.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/nnsa_ctrl.sv =====
// Controller: sequences one pixel through the datapath and tracks the active rectangle.
// Depends on nnsa_pkg.
module nnsa_ctrl
   import nnsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_restart,
   output logic                 req_tready,
   input  nnsa_pkg::status_type status,
   output nnsa_pkg::cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      busy_in    = busy_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_restart && status.dims_empty) begin
                  cmd.clear = 1'b1;
                  busy_in   = 1'b0;
               end else if (req_restart || busy_ff) begin
                  cmd.emit = 1'b1;
                  busy_in  = !status.pix_last;
                  state_in = ST_START_X;
               end
            end
         end
         ST_START_X: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_X;
         end
         ST_DIV_X: begin
            if (status.div_done) begin
               cmd.cap_x     = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_y = 1'b1;
               state_in      = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (status.div_done) begin
               cmd.cap_y = 1'b1;
               state_in  = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            cmd.calc_off = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/nearest_neighbor_scaler_addr.sv =====
// Nearest-neighbor scaler address generator, top level.
// A new request is taken only after the last response is in the output register,
// and the shared 24-step divider runs once for the column and once for the row.
// Items with no response (empty rectangle, advance while idle) end in the idle state.
// Synchronous active-high reset clears the counters, the rectangle state and the
// registers to their defaults (pitches 1, all else 0); the output holds no transfer.
module nearest_neighbor_scaler_addr
   import nnsa_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [nnsa_pkg::REQ_DATA_W-1:0] req_tdata,  // [0] restart
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nnsa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [23:0] src_addr, [47:24] dst_addr
   output logic                            rsp_tlast,
   input  logic                            csr_wen,
   input  logic [nnsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic       req_restart;

   assign req_restart = req_tdata[0];

   nnsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_restart),
      .req_tready  (req_tready),
      .status      (status),
      .cmd         (cmd)
   );

   nnsa_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_restart (req_restart),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== hw/rtl/nnsa_checker.sv =====
// Port checker for the nearest-neighbor scaler address generator, bound to the top level.
// Depends on nnsa_pkg and nearest_neighbor_scaler_addr_assert.svh.
`include "nearest_neighbor_scaler_addr_assert.svh"
module nnsa_checker
   import nnsa_pkg::*;
(
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nnsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   property p_rsp_hold;
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast);
   endproperty

   property p_rsp_rise_busy;
      $rose(rsp_tvalid) |-> !$past(req_tready);
   endproperty

   property p_no_instant_rsp;
      req_tvalid && req_tready |=> !$rose(rsp_tvalid);
   endproperty

   `NNSA_CHECK_RST(a_reset_empty, reset |=> !rsp_tvalid, "response valid after reset")
   `NNSA_CHECK(a_rsp_hold, p_rsp_hold, "stalled response changed")
   `NNSA_CHECK(a_rsp_rise_busy, p_rsp_rise_busy, "response loaded while accepting requests")
   `NNSA_CHECK(a_no_instant_rsp, p_no_instant_rsp, "response one cycle after request")

endmodule

bind nearest_neighbor_scaler_addr nnsa_checker u_nnsa_checker (.*);
